>>> rtl/core/bmprle_pkg.sv
// Shared types and codes for the bitmap RLE span decoder.
package bmprle_pkg;

   localparam int unsigned DEFAULT_MAX_DIMENSION = 4096;

   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = 13;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_RLE4_MODE    = 2'd0,
      CSR_IMAGE_WIDTH  = 2'd1,
      CSR_IMAGE_HEIGHT = 2'd2
   } csr_index_type;

   localparam logic [1:0] ST_SPAN    = 2'd0;
   localparam logic [1:0] ST_END     = 2'd1;
   localparam logic [1:0] ST_WIDE    = 2'd2;
   localparam logic [1:0] ST_IGNORED = 2'd3;

   localparam logic [7:0] ESC_END_OF_LINE   = 8'h00;
   localparam logic [7:0] ESC_END_OF_BITMAP = 8'h01;
   localparam logic [7:0] ESC_DELTA         = 8'h02;

   localparam logic [15:0] COLUMN_MAX = 16'hFFFF;
   localparam logic [12:0] LINE_MAX   = 13'h1FFF;

   typedef enum logic [2:0] {
      PH_COUNT = 3'd0,
      PH_VALUE = 3'd1,
      PH_ESC   = 3'd2,
      PH_DX    = 3'd3,
      PH_DY    = 3'd4,
      PH_ABS   = 3'd5,
      PH_PAD   = 3'd6
   } phase_type;

   typedef struct packed {
      logic [7:0] stream_byte;
      logic       restart;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [11:0] memory_row;
      logic [15:0] start_column;
      logic [7:0]  span_length;
      logic [7:0]  first_color;
      logic [7:0]  second_color;
   } rsp_word_type;

endpackage

>>> rtl/core/bmp_rle_span_decoder_core.sv
// Top level of the bitmap RLE8/RLE4 span decoder: decode state, result register and skid.
//
// The decoder takes one compressed byte per cycle while req_stall is low and turns each run
// into a span word (row, start column, length, two alternating colors) on the rsp_ channel.
// Each byte is decoded in the cycle it is accepted, through a combinational update of the
// decode state (phase, counters, column and line position), so the sustained rate is one
// byte per cycle. Results go to the output register, or the skid entry behind a stalled
// word. Count, end-of-line, delta and pad bytes give no word unless they end the bitmap or
// follow its end. An output register plus one skid entry separate the two sides; req_stall
// rises only while the skid entry holds a word, that is, after the consumer has stalled for
// two results in a row. Configuration registers are written through the csr_ port, which is
// always ready, and must only be written while no word is still in flight.
module bmp_rle_span_decoder_core #(
   parameter int unsigned MAX_DIMENSION = bmprle_pkg::DEFAULT_MAX_DIMENSION
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  bmprle_pkg::req_word_type               req_payload,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output bmprle_pkg::rsp_word_type               rsp_payload,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [bmprle_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [bmprle_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import bmprle_pkg::*;

   localparam logic [15:0] DimLimit = 16'(MAX_DIMENSION);

   // Configuration registers.
   logic        rle4_mode_ff;
   logic [12:0] image_width_ff;
   logic [12:0] image_height_ff;

   // Decode state.
   phase_type   phase_ff, phase_in;
   logic [7:0]  run_count_ff, run_count_in;
   logic [7:0]  absolute_left_ff, absolute_left_in;
   logic        pad_pending_ff, pad_pending_in;
   logic [15:0] column_pos_ff, column_pos_in;
   logic [12:0] line_pos_ff, line_pos_in;
   logic        finished_ff, finished_in;

   // Output register and skid entry.
   logic         out_valid_ff, out_valid_in;
   rsp_word_type out_word_ff, out_word_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_word_type skid_word_ff, skid_word_in;

   logic         accept;
   logic         res_valid;
   rsp_word_type res_word;

   logic [15:0] width_limit;
   logic [15:0] height_limit;
   logic [7:0]  in_byte;

   logic        span_en;
   logic [7:0]  span_len;
   logic [7:0]  span_a;
   logic [7:0]  span_b;
   logic        end_en;
   logic [16:0] span_end;
   logic [16:0] col_sum;
   logic [13:0] line_sum;
   logic [15:0] row_full;

   assign csr_ready = 1'b1;
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign in_byte   = req_payload.stream_byte;

   assign width_limit  = ({3'b000, image_width_ff} > DimLimit) ? DimLimit
                                                               : {3'b000, image_width_ff};
   assign height_limit = ({3'b000, image_height_ff} > DimLimit) ? DimLimit
                                                                : {3'b000, image_height_ff};

   always_comb begin
      phase_in         = phase_ff;
      run_count_in     = run_count_ff;
      absolute_left_in = absolute_left_ff;
      pad_pending_in   = pad_pending_ff;
      column_pos_in    = column_pos_ff;
      line_pos_in      = line_pos_ff;
      finished_in      = finished_ff;
      span_en          = 1'b0;
      span_len         = 8'd0;
      span_a           = 8'd0;
      span_b           = 8'd0;
      end_en           = 1'b0;
      res_valid        = 1'b0;
      res_word         = '0;
      col_sum          = 17'd0;
      line_sum         = 14'd0;
      span_end         = 17'd0;
      row_full         = 16'd0;

      if (req_payload.restart) begin
         phase_in         = PH_COUNT;
         run_count_in     = 8'd0;
         absolute_left_in = 8'd0;
         pad_pending_in   = 1'b0;
         column_pos_in    = 16'd0;
         line_pos_in      = 13'd0;
         finished_in      = 1'b0;
      end

      if (finished_in) begin
         res_valid       = 1'b1;
         res_word.status = ST_IGNORED;
      end else if ({3'b000, line_pos_in} >= height_limit) begin
         end_en = 1'b1;
      end else begin
         case (phase_in)
            PH_VALUE: begin
               phase_in = PH_COUNT;
               span_en  = 1'b1;
               span_len = run_count_in;
               span_a   = rle4_mode_ff ? {4'd0, in_byte[7:4]} : in_byte;
               span_b   = rle4_mode_ff ? {4'd0, in_byte[3:0]} : in_byte;
            end
            PH_ESC: begin
               phase_in = PH_COUNT;
               if (in_byte == ESC_END_OF_LINE) begin
                  column_pos_in = 16'd0;
                  line_sum      = {1'b0, line_pos_in} + 14'd1;
                  line_pos_in   = (line_sum > {1'b0, LINE_MAX}) ? LINE_MAX : line_sum[12:0];
                  end_en        = ({3'b000, line_pos_in} >= height_limit);
               end else if (in_byte == ESC_END_OF_BITMAP) begin
                  end_en = 1'b1;
               end else if (in_byte == ESC_DELTA) begin
                  phase_in = PH_DX;
               end else begin
                  absolute_left_in = in_byte;
                  // RLE4 pads when the run's pixel count is one or two past a multiple of four (odd byte count).
                  pad_pending_in   = rle4_mode_ff ? (in_byte[1] ^ in_byte[0]) : in_byte[0];
                  phase_in         = PH_ABS;
               end
            end
            PH_DX: begin
               col_sum       = {1'b0, column_pos_in} + {9'd0, in_byte};
               column_pos_in = (col_sum > {1'b0, COLUMN_MAX}) ? COLUMN_MAX : col_sum[15:0];
               phase_in      = PH_DY;
            end
            PH_DY: begin
               line_sum    = {1'b0, line_pos_in} + {6'd0, in_byte};
               line_pos_in = (line_sum > {1'b0, LINE_MAX}) ? LINE_MAX : line_sum[12:0];
               phase_in    = PH_COUNT;
               end_en      = ({3'b000, line_pos_in} >= height_limit);
            end
            PH_ABS: begin
               span_en = 1'b1;
               if (rle4_mode_ff && absolute_left_in >= 8'd2) begin
                  span_len = 8'd2;
                  span_a   = {4'd0, in_byte[7:4]};
                  span_b   = {4'd0, in_byte[3:0]};
               end else if (rle4_mode_ff) begin
                  span_len = 8'd1;
                  span_a   = {4'd0, in_byte[7:4]};
                  span_b   = 8'd0;
               end else begin
                  span_len = 8'd1;
                  span_a   = in_byte;
                  span_b   = in_byte;
               end
               if (absolute_left_in <= span_len) begin
                  absolute_left_in = 8'd0;
                  phase_in         = pad_pending_in ? PH_PAD : PH_COUNT;
               end else begin
                  absolute_left_in = absolute_left_in - span_len;
               end
            end
            PH_PAD: begin
               phase_in       = PH_COUNT;
               pad_pending_in = 1'b0;
            end
            default: begin
               if (in_byte == 8'd0) begin
                  phase_in = PH_ESC;
               end else begin
                  run_count_in = in_byte;
                  phase_in     = PH_VALUE;
               end
            end
         endcase
      end

      if (end_en) begin
         finished_in     = 1'b1;
         phase_in        = PH_COUNT;
         res_valid       = 1'b1;
         res_word.status = ST_END;
      end else if (span_en) begin
         span_end              = {1'b0, column_pos_in} + {9'd0, span_len};
         row_full              = height_limit - 16'd1 - {3'b000, line_pos_in};
         res_valid             = 1'b1;
         res_word.status       = (span_end > {1'b0, width_limit}) ? ST_WIDE : ST_SPAN;
         res_word.memory_row   = row_full[11:0];
         res_word.start_column = column_pos_in;
         res_word.span_length  = span_len;
         res_word.first_color  = span_a;
         res_word.second_color = span_b;
         column_pos_in = (span_end > {1'b0, COLUMN_MAX}) ? COLUMN_MAX : span_end[15:0];
      end
   end

   // Output register with one skid entry behind it.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_word_in   = out_word_ff;
      skid_valid_in = skid_valid_ff;
      skid_word_in  = skid_word_ff;
      if (!out_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_word_in   = skid_word_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = accept && res_valid;
            out_word_in  = res_word;
         end
      end else if (accept && res_valid) begin
         skid_valid_in = 1'b1;
         skid_word_in  = res_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rle4_mode_ff     <= 1'b0;
         image_width_ff   <= 13'd1;
         image_height_ff  <= 13'd1;
         phase_ff         <= PH_COUNT;
         run_count_ff     <= 8'd0;
         absolute_left_ff <= 8'd0;
         pad_pending_ff   <= 1'b0;
         column_pos_ff    <= 16'd0;
         line_pos_ff      <= 13'd0;
         finished_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         skid_valid_ff    <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_RLE4_MODE:    rle4_mode_ff    <= csr_wdata[0];
               CSR_IMAGE_WIDTH:  image_width_ff  <= csr_wdata;
               CSR_IMAGE_HEIGHT: image_height_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (accept) begin
            phase_ff         <= phase_in;
            run_count_ff     <= run_count_in;
            absolute_left_ff <= absolute_left_in;
            pad_pending_ff   <= pad_pending_in;
            column_pos_ff    <= column_pos_in;
            line_pos_ff      <= line_pos_in;
            finished_ff      <= finished_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_word_ff  <= out_word_in;
      skid_word_ff <= skid_word_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_word_ff;

   // The skid entry only fills behind a stalled output word.
   a_skid_behind_output: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry holds a word while the output register is empty");

   a_finished_phase: assert property (@(posedge clock) disable iff (reset)
      finished_ff |-> (phase_ff == PH_COUNT))
      else $error("decoder finished outside the count phase");

   a_pad_needs_flag: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAD) |-> pad_pending_ff)
      else $error("pad phase entered without a pending pad byte");

   a_end_word_empty: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_word_ff.status == ST_END || out_word_ff.status == ST_IGNORED))
      |-> (out_word_ff.span_length == 8'd0 && out_word_ff.start_column == 16'd0))
      else $error("end or ignored word carries span fields");

endmodule

>>> tb/tb.sv
// Self-checking testbench for the bitmap RLE8/RLE4 span decoder core.
`timescale 1ns / 1ps

module tb;
   import bmprle_pkg::*;

   localparam int unsigned DIM_LIMIT   = DEFAULT_MAX_DIMENSION;
   localparam int          HOLD_CYCLES = 300;
   localparam int          CYCLE_LIMIT = 400000;

   // Mirrors the decode state and registers and queues the span words each byte should give.
   class span_scoreboard;
      bit          rle4;
      logic [12:0] width_reg;
      logic [12:0] height_reg;
      phase_type   state;
      logic [7:0]  count_latched;
      logic [7:0]  abs_remaining;
      bit          pad_owed;
      int unsigned x_pos;
      int unsigned y_pos;
      bit          done_flag;
      rsp_word_type expected_q[$];
      int          errors;

      function new();
         rle4 = 1'b0;
         width_reg = 13'd1;
         height_reg = 13'd1;
         state = PH_COUNT;
         count_latched = '0;
         abs_remaining = '0;
         pad_owed = 1'b0;
         x_pos = 0;
         y_pos = 0;
         done_flag = 1'b0;
         errors = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [12:0] value);
         case (idx)
            CSR_RLE4_MODE:    rle4 = value[0];
            CSR_IMAGE_WIDTH:  width_reg = value;
            CSR_IMAGE_HEIGHT: height_reg = value;
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function int unsigned dim(logic [12:0] value);
         int unsigned u;
         u = value;
         return (u > DIM_LIMIT) ? DIM_LIMIT : u;
      endfunction

      function void push_word(logic [1:0] st, int unsigned row, int unsigned col,
                              int unsigned len, int unsigned a, int unsigned b);
         rsp_word_type w;
         w.status = st;
         w.memory_row = row[11:0];
         w.start_column = col[15:0];
         w.span_length = len[7:0];
         w.first_color = a[7:0];
         w.second_color = b[7:0];
         expected_q.push_back(w);
      endfunction

      function void end_image();
         done_flag = 1'b1;
         state = PH_COUNT;
         push_word(ST_END, 0, 0, 0, 0, 0);
      endfunction

      function void emit_span(int unsigned h, int unsigned len, int unsigned a, int unsigned b);
         int unsigned stop;
         stop = x_pos + len;
         push_word((stop > dim(width_reg)) ? ST_WIDE : ST_SPAN, h - 1 - y_pos, x_pos, len, a, b);
         x_pos = (stop > COLUMN_MAX) ? COLUMN_MAX : stop;
      endfunction

      function void note_byte(req_word_type w);
         int unsigned h;
         int unsigned len;
         int unsigned a;
         int unsigned b;
         int unsigned t;
         logic [7:0]  d;
         d = w.stream_byte;
         h = dim(height_reg);
         if (w.restart) begin
            state = PH_COUNT;
            count_latched = '0;
            abs_remaining = '0;
            pad_owed = 1'b0;
            x_pos = 0;
            y_pos = 0;
            done_flag = 1'b0;
         end
         if (done_flag) begin
            push_word(ST_IGNORED, 0, 0, 0, 0, 0);
            return;
         end
         // A height lowered below the current line ends the image on the next byte.
         if (y_pos >= h) begin
            end_image();
            return;
         end
         case (state)
            PH_VALUE: begin
               state = PH_COUNT;
               if (rle4) emit_span(h, count_latched, d[7:4], d[3:0]);
               else emit_span(h, count_latched, d, d);
            end
            PH_ESC: begin
               state = PH_COUNT;
               if (d == ESC_END_OF_LINE) begin
                  x_pos = 0;
                  y_pos = (y_pos + 1 > LINE_MAX) ? LINE_MAX : y_pos + 1;
                  if (y_pos >= h) end_image();
               end else if (d == ESC_END_OF_BITMAP) begin
                  end_image();
               end else if (d == ESC_DELTA) begin
                  state = PH_DX;
               end else begin
                  abs_remaining = d;
                  pad_owed = rle4 ? (d[1:0] == 2'd1 || d[1:0] == 2'd2) : d[0];
                  state = PH_ABS;
               end
            end
            PH_DX: begin
               t = x_pos + d;
               x_pos = (t > COLUMN_MAX) ? COLUMN_MAX : t;
               state = PH_DY;
            end
            PH_DY: begin
               t = y_pos + d;
               y_pos = (t > LINE_MAX) ? LINE_MAX : t;
               state = PH_COUNT;
               if (y_pos >= h) end_image();
            end
            PH_ABS: begin
               if (rle4 && abs_remaining >= 2) begin
                  len = 2; a = d[7:4]; b = d[3:0];
               end else if (rle4) begin
                  len = 1; a = d[7:4]; b = 0;
               end else begin
                  len = 1; a = d; b = d;
               end
               if (abs_remaining <= len) begin
                  abs_remaining = '0;
                  state = pad_owed ? PH_PAD : PH_COUNT;
               end else begin
                  abs_remaining = abs_remaining - len[7:0];
               end
               emit_span(h, len, a, b);
            end
            PH_PAD: begin
               state = PH_COUNT;
               pad_owed = 1'b0;
            end
            default: begin
               if (d == 8'h00) begin
                  state = PH_ESC;
               end else begin
                  count_latched = d;
                  state = PH_VALUE;
               end
            end
         endcase
      endfunction

      function void report(string what, rsp_word_type want, rsp_word_type got);
         errors++;
         if (errors <= 10)
            $display("%s: status %0d/%0d row %0d/%0d col %0d/%0d len %0d/%0d colors %0h,%0h/%0h,%0h",
                     what, want.status, got.status, want.memory_row, got.memory_row,
                     want.start_column, got.start_column, want.span_length, got.span_length,
                     want.first_color, want.second_color, got.first_color, got.second_color);
      endfunction

      function void check_word(rsp_word_type got);
         rsp_word_type want;
         if (expected_q.size() == 0) begin
            report("unexpected word (expected/actual)", '0, got);
            return;
         end
         want = expected_q.pop_front();
         if (got.status !== want.status || got.memory_row !== want.memory_row ||
             got.start_column !== want.start_column || got.span_length !== want.span_length ||
             got.first_color !== want.first_color || got.second_color !== want.second_color)
            report("word mismatch (expected/actual)", want, got);
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_payload;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_word_type rsp_payload;
   logic         csr_valid;
   logic         csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;

   span_scoreboard sb;
   logic [7:0] byte_q[$];
   int         phase_items;
   int         burst_left;
   bit         gaps_on;
   bit         hold_request;
   int         cycle_count;

   bmp_rle_span_decoder_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL bmp_rle_span_decoder_core");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         sb.check_word(rsp_payload);
   end

   // Result side: stall styles change at random intervals; a hold request parks it.
   initial begin
      int  style;
      int  style_left;
      logic s;
      rsp_stall = 1'b0;
      style = 0;
      style_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end
         if (style_left == 0) begin
            style = $urandom_range(0, 3);
            style_left = $urandom_range(10, 80);
         end
         style_left--;
         case (style)
            0: s = 1'b0;
            1: s = ($urandom_range(0, 3) == 0);
            2: s = ($urandom_range(0, 4) != 0);
            default: s = ~rsp_stall;
         endcase
         rsp_stall <= s;
      end
   end

   task automatic idle_gap();
      int n;
      n = $urandom_range(1, 6);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic drive_byte(input logic [7:0] value, input logic restart_bit);
      req_word_type w;
      w.stream_byte = value;
      w.restart = restart_bit;
      @(negedge clock);
      req_payload <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
      if (!(sb.done_flag && !restart_bit)) phase_items++;
      sb.note_byte(w);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 24);
         if (gaps_on) idle_gap();
      end
   endtask

   task automatic drive_queue(input logic restart_first);
      for (int i = 0; i < byte_q.size(); i++)
         drive_byte(byte_q[i], (i == 0) ? restart_first : 1'b0);
   endtask

   // Waits until every expected word has come back and the block has gone quiet.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [12:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.set_reg(idx, value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(input bit mode, input logic [12:0] width, input logic [12:0] height);
      write_reg(CSR_RLE4_MODE, {12'd0, mode});
      write_reg(CSR_IMAGE_WIDTH, width);
      write_reg(CSR_IMAGE_HEIGHT, height);
   endtask

   // One encoded construct, mostly well formed; a share is loose noise bytes.
   task automatic gen_sequence();
      int   kind;
      int   n;
      int   k;
      logic rs;
      rs = sb.done_flag || ($urandom_range(0, 40) == 0);
      byte_q.delete();
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
         n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 12);
         byte_q.push_back(n[7:0]);
         byte_q.push_back(8'($urandom));
      end else if (kind < 60) begin
         n = ($urandom_range(0, 7) == 0) ? $urandom_range(3, 255) : $urandom_range(3, 12);
         byte_q.push_back(8'h00);
         byte_q.push_back(n[7:0]);
         k = sb.rle4 ? (n + 1) / 2 : n;
         repeat (k) byte_q.push_back(8'($urandom));
         if (sb.rle4 ? (n % 4 == 1 || n % 4 == 2) : (n % 2 == 1))
            byte_q.push_back(8'($urandom));
      end else if (kind < 70) begin
         byte_q.push_back(8'h00);
         byte_q.push_back(ESC_END_OF_LINE);
      end else if (kind < 78) begin
         byte_q.push_back(8'h00);
         byte_q.push_back(ESC_DELTA);
         byte_q.push_back(8'($urandom));
         byte_q.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2)));
      end else if (kind < 81) begin
         byte_q.push_back(8'h00);
         byte_q.push_back(ESC_END_OF_BITMAP);
      end else begin
         n = $urandom_range(1, 3);
         repeat (n) byte_q.push_back(8'($urandom));
         if ($urandom_range(0, 5) == 0) rs = 1'b1;
      end
      drive_queue(rs);
   endtask

   task automatic run_items(input int n);
      int stop;
      stop = phase_items + n;
      while (phase_items < stop) gen_sequence();
   endtask

   initial begin
      logic [12:0] width;
      logic [12:0] height;
      int          n;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      hold_request = 1'b0;
      gaps_on = 1'b1;
      burst_left = 8;
      phase_items = 0;
      cycle_count = 0;
      sb = new();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // RLE8: plain run, run past the row, end of line, delta, odd absolute run with
      // its pad, end of bitmap, then a byte that must be ignored.
      configure(1'b0, 13'd16, 13'd4);
      byte_q = '{8'h05, 8'hAA, 8'hFF, 8'h3C, 8'h00, 8'h00, 8'h00, 8'h02, 8'h03, 8'h01,
                 8'h00, 8'h03, 8'h11, 8'h22, 8'h33, 8'h00, 8'h00, 8'h01, 8'h7F};
      drive_queue(1'b1);
      drain();

      // RLE4: nibble run, absolute run with an odd tail and pad, delta past the height.
      configure(1'b1, 13'd16, 13'd4);
      byte_q = '{8'h03, 8'hAB, 8'h00, 8'h05, 8'h12, 8'h34, 8'h50, 8'h00,
                 8'h00, 8'h02, 8'h00, 8'hFF};
      drive_queue(1'b1);
      drain();

      for (int p = 0; p < 8; p++) begin
         width = ($urandom_range(0, 3) == 0) ? 13'($urandom) : 13'($urandom_range(1, 300));
         height = 13'($urandom_range(2, 24));
         n = 90;
         case (p)
            0: begin width = 13'd4096; height = 13'd4096; end
            1: begin width = 13'd1; height = 13'd1; end
            2: begin width = 13'd8191; height = 13'd8191; end
            3: begin width = 13'd0; height = 13'd0; n = 20; end
            5: height = 13'd1;
            default: ;
         endcase
         configure(p[0], width, height);
         gaps_on = ($urandom_range(0, 3) != 0);
         if (p == 2) hold_request = 1'b1;
         run_items(n / 2);
         if (p == 4) drain();
         run_items(n - n / 2);
         drain();
      end

      // Long row of full runs until the column position saturates, then a wide delta.
      configure(1'b0, 13'd8191, 13'd4096);
      gaps_on = ($urandom_range(0, 1) == 1);
      byte_q.delete();
      repeat (270) begin
         byte_q.push_back(8'hFF);
         byte_q.push_back(8'($urandom));
      end
      byte_q.push_back(8'h00);
      byte_q.push_back(ESC_DELTA);
      byte_q.push_back(8'hFF);
      byte_q.push_back(8'h00);
      byte_q.push_back(8'h04);
      byte_q.push_back(8'h5A);
      drive_queue(1'b1);

      drain();
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("PASS bmp_rle_span_decoder_core");
      else
         $display("FAIL bmp_rle_span_decoder_core");
      $finish;
   end

endmodule
